@@ rtl/core/unique_key_record_table_core_assert.svh @@
// Assertion macros shared by the record table RTL.
// Each macro expands to one labeled concurrent assertion; no other dependencies.
`ifndef UNIQUE_KEY_RECORD_TABLE_CORE_ASSERT_SVH
`define UNIQUE_KEY_RECORD_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UKRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ukrt_pkg.sv @@
// Shared types and constants for the unique-key record table.
// No dependencies; imported by the table core.
`default_nettype none

package ukrt_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int KEY_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int KIND_BITS        = 3;
    localparam int POS_BITS         = 6;
    localparam int STATUS_BITS      = 3;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INSERT = 3'd0,
        KIND_UPDATE = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_LOOKUP = 3'd3,
        KIND_READ   = 3'd4,
        KIND_WRITE  = 3'd5
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_POS   = 3'd4
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/ukrt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ukrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/unique_key_record_table_core.sv @@
// Unique-key record table core: packed table of (key, payload) records.
// Depends on ukrt_pkg, ukrt_ram and unique_key_record_table_core_assert.svh.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge where start is
//   high and busy is low; kind, key, payload and position are sampled then.
//   Result channel: done pulses for one cycle with status, found, key_out,
//   payload_out and count; the receiver cannot stall, so the result is gone
//   after that cycle. count always shows the current entry count.
// Transaction flow:
//   unused kinds, full insert, bad position: result straight from idle;
//   read or write at position: address in S_POS_RD, data in S_POS_DATA;
//   insert, update, lookup: key scan, one entry per cycle through the RAM
//   read port, compare in the cycle after the read; with no match the scan
//   ends once no read is left to compare;
//   remove: scan to the match, then the shift walk moves each later entry
//   one per cycle from the read port to the write port.
//   Worst case is a remove on a full table, set by the single-read-port
//   RAM walk. busy stays high during a scan, walk or position access; done
//   arrives in the first cycle busy is low again, and a new start may be
//   taken in that cycle.
// Reset: asynchronous, active low; empties the table (count 0) at once.
//   RAM contents are not cleared; only entries below count are ever read.
`default_nettype none

`include "unique_key_record_table_core_assert.svh"

module unique_key_record_table_core #(
    parameter int DEPTH        = ukrt_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = ukrt_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ukrt_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ukrt_pkg::KIND_BITS-1:0]   kind,
    input  logic [KEY_BITS-1:0]              key,
    input  logic [PAYLOAD_BITS-1:0]          payload,
    input  logic [ukrt_pkg::POS_BITS-1:0]    position,
    output logic                             done,
    output logic [ukrt_pkg::STATUS_BITS-1:0] status,
    output logic                             found,
    output logic [KEY_BITS-1:0]              key_out,
    output logic [PAYLOAD_BITS-1:0]          payload_out,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    import ukrt_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_BITS) ? CW : POS_BITS;
    localparam int RW    = KEY_BITS + PAYLOAD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_POS_RD,
        S_POS_DATA
    } state_t;

    state_t                 state_reg, state_next;
    logic [KIND_BITS-1:0]   kind_reg, kind_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic                   found_reg, found_next;
    logic [KEY_BITS-1:0]    key_out_reg, key_out_next;
    logic [PAYLOAD_BITS-1:0] payload_out_reg, payload_out_next;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [CMP_W-1:0]        in_pos_ext;
    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        count_ext;
    logic [CW-1:0]           shift_dst;
    logic                    hit;
    logic                    rd_issue;

    assign rd_key     = ram_rdata[PAYLOAD_BITS +: KEY_BITS];
    assign rd_pay     = ram_rdata[PAYLOAD_BITS-1:0];
    assign in_pos_ext = CMP_W'(position);
    assign pos_ext    = CMP_W'(pos_reg);
    assign count_ext  = CMP_W'(count_reg);
    assign shift_dst  = scan_reg - CW'(1);

    ukrt_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        payload_next     = payload_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        scan_next        = scan_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        done_next        = 1'b0;
        status_next      = ST_OK;
        found_next       = 1'b0;
        key_out_next     = '0;
        payload_out_next = '0;
        ram_we           = 1'b0;
        ram_waddr        = cmp_idx_reg;
        ram_wdata        = {key_reg, payload_reg};
        ram_raddr        = scan_reg[AW-1:0];
        hit              = cmp_valid_reg && (rd_key == key_reg);
        rd_issue         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Latch the transaction and start the scan at entry 0
                    kind_next    = kind;
                    key_next     = key;
                    payload_next = payload;
                    pos_next     = position;
                    scan_next    = '0;
                    case (kind) inside
                        KIND_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        KIND_UPDATE, KIND_REMOVE, KIND_LOOKUP:
                        begin
                            state_next = S_SEARCH;
                        end
                        KIND_READ, KIND_WRITE:
                        begin
                            if (in_pos_ext < count_ext)
                            begin
                                state_next = S_POS_RD;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_POS;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // Read one entry per cycle; compare the entry read last cycle
                rd_issue       = !hit && (scan_reg < count_reg);
                cmp_valid_next = rd_issue;
                cmp_idx_next   = scan_reg[AW-1:0];
                if (rd_issue)
                begin
                    scan_next = scan_reg + CW'(1);
                end

                if (hit)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    unique case (kind_reg)
                        KIND_INSERT:
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        KIND_UPDATE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cmp_idx_reg;
                        end
                        KIND_REMOVE:
                        begin
                            // Hold the result; walk the tail down first
                            state_next     = S_SHIFT;
                            done_next      = 1'b0;
                            scan_next      = CW'(cmp_idx_reg) + CW'(1);
                            cmp_valid_next = 1'b0;
                        end
                        KIND_LOOKUP:
                        begin
                            found_next = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
                else if (!cmp_valid_reg && !rd_issue)
                begin
                    // Scan exhausted without a match
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (kind_reg == KIND_INSERT)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read entry src, write it to src-1 in the next cycle
                rd_issue       = scan_reg < count_reg;
                cmp_valid_next = rd_issue;
                cmp_idx_next   = shift_dst[AW-1:0];
                if (rd_issue)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (cmp_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cmp_idx_reg;
                    ram_wdata = ram_rdata;
                end
                else if (!rd_issue)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end

            S_POS_RD:
            begin
                ram_raddr  = pos_ext[AW-1:0];
                state_next = S_POS_DATA;
            end

            S_POS_DATA:
            begin
                ram_raddr        = pos_ext[AW-1:0];
                state_next       = S_IDLE;
                done_next        = 1'b1;
                key_out_next     = rd_key;
                payload_out_next = rd_pay;
                if (kind_reg == KIND_WRITE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_ext[AW-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    // Command, scan and result registers here carry no reset
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        payload_reg     <= payload_next;
        pos_reg         <= pos_next;
        scan_reg        <= scan_next;
        cmp_idx_reg     <= cmp_idx_next;
        status_reg      <= status_next;
        found_reg       <= found_next;
        key_out_reg     <= key_out_next;
        payload_out_reg <= payload_out_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign key_out     = key_out_reg;
    assign payload_out = payload_out_reg;
    assign count       = count_reg;

    `UKRT_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH), "count exceeds depth")
    `UKRT_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "done while busy")
    `UKRT_ASSERT_IMPL(a_we_busy, clk, rst_n, ram_we, state_reg != S_IDLE, "RAM write while idle")
    `UKRT_ASSERT_NEXT(a_count_done, clk, rst_n, count_next != count_reg, done_reg, "count moved without a result")
    `UKRT_ASSERT_IMPL(a_found_ok, clk, rst_n, done_reg && found_reg, status_reg == ST_OK, "found with error status")

endmodule

`default_nettype wire
